FILE: design/lcasr_pkg.sv
// Shared types and constants for the load-cell converter serial reader.
package lcasr_pkg;

	// Widths of the fixed payload fields.
	localparam int unsigned HALF_W    = 16;
	localparam int unsigned PULSE_W   = 5;
	localparam int unsigned SAMPLE_W  = 24;
	localparam int unsigned CHAR_W    = 8;
	localparam int unsigned GAIN_W    = 8;
	localparam int unsigned CFG_IDX_W = 1;

	// Default number of data bits shifted in per conversion.
	localparam int unsigned DATA_BITS_DEF = 24;

	// Depth of the queue between the front and back parts.
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_MODE  = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [HALF_W-1:0] HALF_PERIOD_RST = 16'd100;

	// Pulse counts that select channel and gain for the next conversion.
	localparam logic [PULSE_W-1:0] PULSES_A128 = 5'd25;
	localparam logic [PULSE_W-1:0] PULSES_B32  = 5'd26;
	localparam logic [PULSE_W-1:0] PULSES_A64  = 5'd27;

	// Channel letters and gain codes.
	localparam logic [CHAR_W-1:0] CHAR_A_LO = 8'h61;
	localparam logic [CHAR_W-1:0] CHAR_A_UP = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_B_LO = 8'h62;
	localparam logic [CHAR_W-1:0] CHAR_B_UP = 8'h42;
	localparam logic [GAIN_W-1:0] GAIN_128  = 8'd128;
	localparam logic [GAIN_W-1:0] GAIN_64   = 8'd64;
	localparam logic [GAIN_W-1:0] GAIN_32   = 8'd32;

	// Phases of the serial transfer sequencer.
	typedef enum logic [1:0] {
		PH_IDLE,
		PH_WAIT,
		PH_HIGH,
		PH_LOW
	} lcasr_phase_t;

	// One classified tick as it travels from the front to the back.
	typedef struct packed {
		logic               dout;
		logic               req;
		logic [PULSE_W-1:0] target;
		logic               warn;
	} lcasr_item_t;

	// Configuration seen by the back part.
	typedef struct packed {
		logic [HALF_W-1:0] half_period;
		logic              sleep_mode;
	} lcasr_cfg_t;

endpackage

FILE: design/load_cell_adc_serial_reader_top.sv
// An accepted word is stored in the queue, then in the output register, before its result word appears.
// Throughput: one word per cycle while no stall holds it; each word is one tick of the converter interface.
// The queue between the front and back parts is two words deep.
// Reset clears the sequencer to idle, pulse history to channel A gain 128,
// half period to 100 ticks and power down to off. No clearing pass is needed.
module load_cell_adc_serial_reader_top #(
	parameter int unsigned DATA_BITS = lcasr_pkg::DATA_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [lcasr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lcasr_pkg::HALF_W-1:0]          cfg_wdata,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  dout,
	input  logic                                  start_req,
	input  logic [lcasr_pkg::CHAR_W-1:0]          channel_char,
	input  logic [lcasr_pkg::GAIN_W-1:0]          gain_code,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  sck,
	output logic                                  busy_res,
	output logic                                  sample_valid,
	output logic signed [lcasr_pkg::SAMPLE_W-1:0] sample,
	output logic                                  request_warning
);

	lcasr_pkg::lcasr_item_t front_item;
	lcasr_pkg::lcasr_item_t q_item;
	lcasr_pkg::lcasr_cfg_t  cfg_q;
	logic                   q_full;
	logic                   q_not_empty;
	logic                   q_pop;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_full;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_period <= lcasr_pkg::HALF_PERIOD_RST;
			cfg_q.sleep_mode  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lcasr_pkg::CFG_HALF_PERIOD: cfg_q.half_period <= cfg_wdata;
				lcasr_pkg::CFG_SLEEP_MODE:  cfg_q.sleep_mode  <= cfg_wdata[0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	lcasr_front u_front (
		.dout         (dout),
		.start_req    (start_req),
		.channel_char (channel_char),
		.gain_code    (gain_code),
		.item         (front_item)
	);

	lcasr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid),
		.push_item (front_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_item  (q_item)
	);

	lcasr_back #(
		.DATA_BITS (DATA_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.q_not_empty     (q_not_empty),
		.q_item          (q_item),
		.q_pop           (q_pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.sck             (sck),
		.busy_res        (busy_res),
		.sample_valid    (sample_valid),
		.sample          (sample),
		.request_warning (request_warning)
	);

endmodule

FILE: design/lcasr_front.sv
// Front part: classifies the request of each incoming word into a pulse count.
module lcasr_front (
	input  logic                         dout,
	input  logic                         start_req,
	input  logic [lcasr_pkg::CHAR_W-1:0] channel_char,
	input  logic [lcasr_pkg::GAIN_W-1:0] gain_code,
	output lcasr_pkg::lcasr_item_t       item
);

	logic is_a;
	logic is_b;

	assign is_a = (channel_char == lcasr_pkg::CHAR_A_LO) || (channel_char == lcasr_pkg::CHAR_A_UP);
	assign is_b = (channel_char == lcasr_pkg::CHAR_B_LO) || (channel_char == lcasr_pkg::CHAR_B_UP);

	// Map channel and gain to a pulse count. An unknown channel falls back to A at gain 128.
	always_comb begin
		item.dout   = dout;
		item.req    = start_req;
		item.target = lcasr_pkg::PULSES_A128;
		item.warn   = 1'b0;
		if (is_a) begin
			if (gain_code == lcasr_pkg::GAIN_64) begin
				item.target = lcasr_pkg::PULSES_A64;
			end else if (gain_code != lcasr_pkg::GAIN_128) begin
				item.warn = 1'b1;
			end
		end else if (is_b) begin
			item.target = lcasr_pkg::PULSES_B32;
			item.warn   = (gain_code != lcasr_pkg::GAIN_32);
		end else begin
			item.warn = 1'b1;
		end
	end

endmodule

FILE: design/lcasr_queue.sv
// Short queue of classified words between the front and back parts.
module lcasr_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  lcasr_pkg::lcasr_item_t push_item,
	output logic                   full,
	input  logic                   pop,
	output logic                   not_empty,
	output lcasr_pkg::lcasr_item_t pop_item
);

	localparam int unsigned CNT_W = $clog2(lcasr_pkg::QUEUE_DEPTH + 1);

	lcasr_pkg::lcasr_item_t                 entry_q [lcasr_pkg::QUEUE_DEPTH];
	logic [lcasr_pkg::QUEUE_PTR_W-1:0]      wr_ptr_q;
	logic [lcasr_pkg::QUEUE_PTR_W-1:0]      rd_ptr_q;
	logic [CNT_W-1:0]                       count_q;
	logic                                   do_push;
	logic                                   do_pop;

	assign full      = (count_q == CNT_W'(lcasr_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_item  = entry_q[rd_ptr_q];

	// Entry storage needs no reset.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == lcasr_pkg::QUEUE_PTR_W'(lcasr_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == lcasr_pkg::QUEUE_PTR_W'(lcasr_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: design/lcasr_back.sv
// Back part: SCK sequencer, data shift register and output register.
module lcasr_back #(
	parameter int unsigned DATA_BITS = lcasr_pkg::DATA_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  lcasr_pkg::lcasr_cfg_t                cfg,
	input  logic                                 q_not_empty,
	input  lcasr_pkg::lcasr_item_t               q_item,
	output logic                                 q_pop,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 sck,
	output logic                                 busy_res,
	output logic                                 sample_valid,
	output logic signed [lcasr_pkg::SAMPLE_W-1:0] sample,
	output logic                                 request_warning
);

	localparam int unsigned PW = lcasr_pkg::PULSE_W;
	localparam int unsigned HW = lcasr_pkg::HALF_W;

	lcasr_pkg::lcasr_phase_t     phase_q, phase_d;
	logic [HW-1:0]               timer_q, timer_d;
	logic [PW-1:0]               pcount_q, pcount_d;
	logic [PW-1:0]               target_q, target_d;
	logic [PW-1:0]               last_q, last_d;
	logic                        dummy_q, dummy_d;
	logic signed [DATA_BITS-1:0] shift_q, shift_d;
	logic [HW-1:0]               reload;
	logic                        sck_d;
	logic                        valid_d;
	logic                        warn_d;
	logic                        out_valid_q;

	// A word is taken from the queue when the output register is free or being emptied.
	assign q_pop     = q_not_empty && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign reload    = (cfg.half_period == '0) ? '0 : cfg.half_period - 1'b1;

	// Next state of the sequencer for one tick.
	always_comb begin
		phase_d  = phase_q;
		timer_d  = timer_q;
		pcount_d = pcount_q;
		target_d = target_q;
		last_d   = last_q;
		dummy_d  = dummy_q;
		shift_d  = shift_q;
		sck_d    = 1'b0;
		valid_d  = 1'b0;
		warn_d   = 1'b0;
		if (cfg.sleep_mode) begin
			phase_d  = lcasr_pkg::PH_IDLE;
			timer_d  = '0;
			pcount_d = '0;
			dummy_d  = 1'b0;
			shift_d  = '0;
			last_d   = lcasr_pkg::PULSES_A128;
			sck_d    = 1'b1;
		end else begin
			case (phase_q)
				lcasr_pkg::PH_IDLE: begin
					if (q_item.req) begin
						warn_d   = q_item.warn;
						target_d = q_item.target;
						dummy_d  = (q_item.target != last_q);
						pcount_d = '0;
						shift_d  = '0;
						phase_d  = lcasr_pkg::PH_WAIT;
					end
				end
				lcasr_pkg::PH_WAIT: begin
					if (!q_item.dout) begin
						pcount_d = '0;
						shift_d  = '0;
						timer_d  = reload;
						phase_d  = lcasr_pkg::PH_HIGH;
						sck_d    = 1'b1;
					end
				end
				lcasr_pkg::PH_HIGH: begin
					if (timer_q == '0) begin
						// Falling edge: sample the data pin for the first data bits.
						if (pcount_q < PW'(DATA_BITS)) begin
							shift_d = {shift_q[DATA_BITS-2:0], q_item.dout};
						end
						pcount_d = pcount_q + 1'b1;
						timer_d  = reload;
						phase_d  = lcasr_pkg::PH_LOW;
					end else begin
						timer_d = timer_q - 1'b1;
						sck_d   = 1'b1;
					end
				end
				lcasr_pkg::PH_LOW: begin
					if (timer_q != '0) begin
						timer_d = timer_q - 1'b1;
					end else if (pcount_q >= target_q) begin
						pcount_d = '0;
						shift_d  = '0;
						if (dummy_q) begin
							// The dummy read only reprograms channel and gain.
							dummy_d = 1'b0;
							phase_d = lcasr_pkg::PH_WAIT;
						end else begin
							valid_d = 1'b1;
							last_d  = target_q;
							phase_d = lcasr_pkg::PH_IDLE;
						end
					end else begin
						timer_d = reload;
						phase_d = lcasr_pkg::PH_HIGH;
						sck_d   = 1'b1;
					end
				end
				default: begin
					phase_d = lcasr_pkg::PH_IDLE;
				end
			endcase
		end
	end

	// Sequencer state, advanced once per word taken from the queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= lcasr_pkg::PH_IDLE;
			timer_q  <= '0;
			pcount_q <= '0;
			target_q <= lcasr_pkg::PULSES_A128;
			last_q   <= lcasr_pkg::PULSES_A128;
			dummy_q  <= 1'b0;
			shift_q  <= '0;
		end else if (q_pop) begin
			phase_q  <= phase_d;
			timer_q  <= timer_d;
			pcount_q <= pcount_d;
			target_q <= target_d;
			last_q   <= last_d;
			dummy_q  <= dummy_d;
			shift_q  <= shift_d;
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload register; the sample is sign-extended from the top data bit.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			sck             <= sck_d;
			busy_res        <= (phase_d != lcasr_pkg::PH_IDLE);
			sample_valid    <= valid_d;
			sample          <= valid_d ? lcasr_pkg::SAMPLE_W'(shift_q) : '0;
			request_warning <= warn_d;
		end
	end

endmodule

FILE: dv/lcasr_checker.sv
// Checker that predicts every result word of the serial reader and compares it.
`timescale 1ns / 1ps

module lcasr_checker #(
	parameter int unsigned DATA_BITS = lcasr_pkg::DATA_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [lcasr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lcasr_pkg::HALF_W-1:0]     cfg_wdata,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  logic                             dout,
	input  logic                             start_req,
	input  logic [lcasr_pkg::CHAR_W-1:0]     channel_char,
	input  logic [lcasr_pkg::GAIN_W-1:0]     gain_code,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  logic                             sck,
	input  logic                             busy_res,
	input  logic                             sample_valid,
	input  logic [lcasr_pkg::SAMPLE_W-1:0]   sample,
	input  logic                             request_warning,
	output int unsigned                      errors,
	output int unsigned                      words_owed,
	output int unsigned                      samples_seen
);
	import lcasr_pkg::*;

	// Pin levels and flags that one tick produces.
	typedef struct packed {
		logic                sck;
		logic                busy;
		logic                valid;
		logic [SAMPLE_W-1:0] sample;
		logic                warn;
	} pin_word_t;

	// Shadow of the sequencer and of its configuration.
	lcasr_phase_t        seq_phase;
	logic [HALF_W-1:0]   half_cnt;
	logic [HALF_W-1:0]   half_period;
	logic                pd;
	logic [PULSE_W-1:0]  pulses_done;
	logic [PULSE_W-1:0]  pulses_target;
	logic [PULSE_W-1:0]  pulses_last;
	logic                redo_pending;
	logic [SAMPLE_W-1:0] shift_reg;

	pin_word_t owed[$];
	pin_word_t want;
	pin_word_t seen;

	// Ticks per half period, less one; a zero period behaves like one.
	function automatic logic [HALF_W-1:0] half_reload();
		return (half_period == '0) ? '0 : half_period - 1'b1;
	endfunction

	// Sign extension of the shifted data bits to the full sample width.
	function automatic logic [SAMPLE_W-1:0] widen(input logic [SAMPLE_W-1:0] v);
		logic [SAMPLE_W-1:0] r;
		r = v;
		for (int i = DATA_BITS; i < SAMPLE_W; i++)
			r[i] = v[DATA_BITS-1];
		return r;
	endfunction

	// Advances the shadow sequencer by one tick and returns the pins it drives.
	task automatic step_reader(input logic d, input logic req, input logic [CHAR_W-1:0] ch,
			input logic [GAIN_W-1:0] g, output pin_word_t w);
		logic [PULSE_W-1:0] tgt;
		w = '0;
		if (pd) begin
			// Power down aborts everything; the converter wakes on channel A, gain 128.
			seq_phase = PH_IDLE;
			half_cnt = '0;
			pulses_done = '0;
			redo_pending = 1'b0;
			shift_reg = '0;
			pulses_last = PULSES_A128;
			w.sck = 1'b1;
		end else begin
			case (seq_phase)
				PH_IDLE: begin
					if (req) begin
						// Bad channels fall back to A at gain 128; B keeps gain 32 regardless.
						tgt = PULSES_A128;
						if (ch == CHAR_A_LO || ch == CHAR_A_UP) begin
							if (g == GAIN_64)
								tgt = PULSES_A64;
							else if (g != GAIN_128)
								w.warn = 1'b1;
						end else if (ch == CHAR_B_LO || ch == CHAR_B_UP) begin
							tgt = PULSES_B32;
							if (g != GAIN_32)
								w.warn = 1'b1;
						end else begin
							w.warn = 1'b1;
						end
						pulses_target = tgt;
						redo_pending = (tgt != pulses_last);
						pulses_done = '0;
						shift_reg = '0;
						seq_phase = PH_WAIT;
					end
				end
				PH_WAIT: begin
					if (!d) begin
						pulses_done = '0;
						shift_reg = '0;
						half_cnt = half_reload();
						seq_phase = PH_HIGH;
						w.sck = 1'b1;
					end
				end
				PH_HIGH: begin
					// The falling edge samples the data pin.
					if (half_cnt == '0) begin
						if (pulses_done < DATA_BITS)
							shift_reg = {shift_reg[SAMPLE_W-2:0], d};
						pulses_done++;
						half_cnt = half_reload();
						seq_phase = PH_LOW;
					end else begin
						half_cnt--;
						w.sck = 1'b1;
					end
				end
				default: begin
					if (half_cnt != '0) begin
						half_cnt--;
					end else if (pulses_done >= pulses_target) begin
						pulses_done = '0;
						if (redo_pending) begin
							// The reprogramming read is thrown away.
							redo_pending = 1'b0;
							shift_reg = '0;
							seq_phase = PH_WAIT;
						end else begin
							w.valid = 1'b1;
							w.sample = widen(shift_reg);
							pulses_last = pulses_target;
							shift_reg = '0;
							seq_phase = PH_IDLE;
						end
					end else begin
						half_cnt = half_reload();
						seq_phase = PH_HIGH;
						w.sck = 1'b1;
					end
				end
			endcase
		end
		w.busy = (seq_phase != PH_IDLE);
	endtask

	task automatic flag(input string field, input logic [SAMPLE_W-1:0] exp_v,
			input logic [SAMPLE_W-1:0] got_v);
		errors++;
		$display("%0t: %s mismatch, expected %h, got %h", $time, field, exp_v, got_v);
	endtask

	// Watch the three channels; predict on input words, compare on output words.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_phase = PH_IDLE;
			half_cnt = '0;
			half_period = HALF_PERIOD_RST;
			pd = 1'b0;
			pulses_done = '0;
			pulses_target = PULSES_A128;
			pulses_last = PULSES_A128;
			redo_pending = 1'b0;
			shift_reg = '0;
			owed.delete();
			errors = 0;
			words_owed = 0;
			samples_seen = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_HALF_PERIOD: half_period = cfg_wdata;
					CFG_SLEEP_MODE:  pd = cfg_wdata[0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				step_reader(dout, start_req, channel_char, gain_code, want);
				owed.push_back(want);
			end
			if (out_valid && !out_stall) begin
				seen = '{sck, busy_res, sample_valid, sample, request_warning};
				if (owed.size() == 0) begin
					errors++;
					$display("%0t: result word with nothing expected, got %h", $time, seen);
				end else begin
					want = owed.pop_front();
					if (seen.sck !== want.sck)
						flag("sck", want.sck, seen.sck);
					if (seen.busy !== want.busy)
						flag("busy_res", want.busy, seen.busy);
					if (seen.valid !== want.valid)
						flag("sample_valid", want.valid, seen.valid);
					if (seen.sample !== want.sample)
						flag("sample", want.sample, seen.sample);
					if (seen.warn !== want.warn)
						flag("request_warning", want.warn, seen.warn);
					if (want.valid)
						samples_seen++;
				end
			end
			words_owed = owed.size();
		end
	end

endmodule

FILE: dv/tb.sv
// Top of the serial reader testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
	import lcasr_pkg::*;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index = CFG_HALF_PERIOD;
	logic [HALF_W-1:0]          cfg_wdata = '0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic                       dout = 1'b1;
	logic                       start_req = 1'b0;
	logic [CHAR_W-1:0]          channel_char = '0;
	logic [GAIN_W-1:0]          gain_code = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic                       sck;
	logic                       busy_res;
	logic                       sample_valid;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       request_warning;

	int unsigned mismatches;
	int unsigned words_owed;
	int unsigned samples_seen;

	int unsigned send_gap_pct = 28;
	int unsigned recv_gap_pct = 51;
	int unsigned ticks_sent = 0;
	int unsigned reg_writes = 0;
	int unsigned reads_done = 0;
	int unsigned half_now = HALF_PERIOD_RST;
	int unsigned last_pulse_cnt = PULSES_A128;

	load_cell_adc_serial_reader_top u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.dout            (dout),
		.start_req       (start_req),
		.channel_char    (channel_char),
		.gain_code       (gain_code),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.sck             (sck),
		.busy_res        (busy_res),
		.sample_valid    (sample_valid),
		.sample          (sample),
		.request_warning (request_warning)
	);

	lcasr_checker u_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.dout            (dout),
		.start_req       (start_req),
		.channel_char    (channel_char),
		.gain_code       (gain_code),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.sck             (sck),
		.busy_res        (busy_res),
		.sample_valid    (sample_valid),
		.sample          (sample),
		.request_warning (request_warning),
		.errors          (mismatches),
		.words_owed      (words_owed),
		.samples_seen    (samples_seen)
	);

	// 50 MHz clock.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// The receiver stalls at random according to the current profile.
	always @(posedge clk) begin
		out_stall <= (recv_gap_pct != 0) && ($urandom_range(99) < recv_gap_pct);
	end

	// Hard stop in case the block hangs.
	initial begin
		#10_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// Sends one tick word after a random gap and holds it until accepted.
	task automatic send_tick(input logic d, input logic req, input logic [CHAR_W-1:0] ch,
			input logic [GAIN_W-1:0] g);
		int unsigned gap;
		logic stalled;
		gap = 0;
		while (gap < 20 && $urandom_range(99) < send_gap_pct)
			gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		dout <= d;
		start_req <= req;
		channel_char <= ch;
		gain_code <= g;
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
		ticks_sent++;
	endtask

	// A tick with the given data level and, now and then, a stray request.
	task automatic pin_tick(input logic d);
		send_tick(d, $urandom_range(99) < 15, 8'($urandom()), 8'($urandom()));
	endtask

	// Stops sending and lets every owed result word arrive.
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (words_owed != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [HALF_W-1:0] val);
		logic ready_seen;
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		do begin
			@(negedge clk);
			ready_seen = cfg_ready;
			@(posedge clk);
		end while (!ready_seen);
		cfg_valid <= 1'b0;
		reg_writes++;
		if (idx == CFG_HALF_PERIOD)
			half_now = val;
	endtask

	// Pulse count a request selects, used to shape the data pin waveform.
	function automatic int unsigned pulses_for(input logic [CHAR_W-1:0] ch,
			input logic [GAIN_W-1:0] g);
		if (ch == CHAR_A_LO || ch == CHAR_A_UP)
			return (g == GAIN_64) ? PULSES_A64 : PULSES_A128;
		if (ch == CHAR_B_LO || ch == CHAR_B_UP)
			return PULSES_B32;
		return PULSES_A128;
	endfunction

	// Plays the converter: busy for a while, then ready, then one data bit per falling edge.
	task automatic clock_out(input logic [SAMPLE_W-1:0] value, input int unsigned n_pulses,
			input int unsigned settle);
		repeat (settle) pin_tick(1'b1);
		pin_tick(1'b0);
		for (int k = 0; k < n_pulses; k++) begin
			repeat (half_now - 1) pin_tick(1'($urandom_range(1)));
			pin_tick(k < SAMPLE_W ? value[SAMPLE_W-1-k] : 1'($urandom_range(1)));
			repeat (half_now - 1) pin_tick(1'($urandom_range(1)));
			pin_tick(1'($urandom_range(1)));
		end
	endtask

	// One complete read, with the reprogramming read first when the pulse count changes.
	task automatic read_once(input logic [CHAR_W-1:0] ch, input logic [GAIN_W-1:0] g,
			input logic [SAMPLE_W-1:0] value);
		int unsigned n;
		n = pulses_for(ch, g);
		send_tick(1'($urandom_range(1)), 1'b1, ch, g);
		if (n != last_pulse_cnt)
			clock_out(24'($urandom()), n, $urandom_range(3));
		clock_out(value, n, $urandom_range(3));
		last_pulse_cnt = n;
		reads_done++;
	endtask

	// Power down for n_ticks ticks with requests that must be ignored.
	task automatic sleep_converter(input int unsigned n_ticks);
		write_reg(CFG_SLEEP_MODE, 16'd1);
		repeat (n_ticks)
			send_tick(1'($urandom_range(1)), 1'($urandom_range(1)), CHAR_A_UP, GAIN_128);
		write_reg(CFG_SLEEP_MODE, 16'd0);
		last_pulse_cnt = PULSES_A128;
	endtask

	// Random well-formed or malformed request with random sample data.
	task automatic random_read();
		logic [CHAR_W-1:0] ch;
		logic [GAIN_W-1:0] g;
		logic [SAMPLE_W-1:0] value;
		ch = $urandom_range(1) ? CHAR_A_UP : CHAR_A_LO;
		g = GAIN_128;
		case ($urandom_range(9))
			0, 1: ;
			2, 3: g = GAIN_64;
			4, 5: begin
				ch = $urandom_range(1) ? CHAR_B_UP : CHAR_B_LO;
				g = GAIN_32;
			end
			6: g = 8'($urandom());
			7: begin
				ch = $urandom_range(1) ? CHAR_B_UP : CHAR_B_LO;
				g = 8'($urandom());
			end
			default: begin
				ch = 8'($urandom());
				g = 8'($urandom());
			end
		endcase
		case ($urandom_range(11))
			0:       value = 24'h7FFFFF;
			1:       value = 24'h800000;
			default: value = 24'($urandom());
		endcase
		read_once(ch, g, value);
	endtask

	initial begin
		int unsigned phase_end;
		int unsigned pick;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed reads: sample extremes, every channel and gain, bad requests.
		write_reg(CFG_HALF_PERIOD, 16'd1);
		read_once(CHAR_A_UP, GAIN_128, 24'h7FFFFF);
		read_once(CHAR_A_LO, GAIN_128, 24'h800000);
		read_once(CHAR_A_UP, GAIN_64, 24'hFFFFFF);
		read_once(CHAR_B_UP, GAIN_32, 24'h000000);
		read_once(CHAR_B_LO, GAIN_32, 24'h5A5A5A);
		read_once(CHAR_B_UP, 8'd7, 24'hA5A5A5);
		read_once(CHAR_A_LO, 8'd33, 24'h123456);
		read_once(8'h00, 8'h00, 24'h000001);
		read_once(8'hFF, 8'hFF, 24'hFFFFFE);
		// Requests during power down are dropped and the gain history resets.
		sleep_converter(4);
		read_once(CHAR_A_UP, GAIN_64, 24'h400000);
		// Slowest half period: SCK held high, then the read is aborted by power down.
		write_reg(CFG_HALF_PERIOD, 16'hFFFF);
		send_tick(1'b1, 1'b1, CHAR_B_UP, GAIN_32);
		pin_tick(1'b0);
		repeat (300) pin_tick(1'($urandom_range(1)));
		sleep_converter(3);

		// Random part under three stall profiles.
		for (int p = 0; p < 3; p++) begin
			send_gap_pct = (p == 0) ? 28 : (p == 1) ? 51 : 0;
			recv_gap_pct = (p == 0) ? 51 : (p == 1) ? 28 : 0;
			write_reg(CFG_HALF_PERIOD, (p == 1) ? 16'd2 : 16'd1);
			phase_end = ticks_sent + 260;
			while (ticks_sent < phase_end) begin
				pick = $urandom_range(99);
				if (pick < 10) begin
					write_reg(CFG_HALF_PERIOD, 16'($urandom_range(1, 3)));
				end else if (pick < 16) begin
					// Read cut short by power down.
					send_tick(1'($urandom_range(1)), 1'b1, 8'($urandom()), 8'($urandom()));
					repeat ($urandom_range(1, 40)) pin_tick(1'($urandom_range(1)));
					sleep_converter($urandom_range(1, 6));
				end else if (pick < 20) begin
					// Pure noise on every pin, then power down to resynchronize.
					repeat ($urandom_range(5, 25)) pin_tick(1'($urandom_range(1)));
					sleep_converter($urandom_range(1, 4));
				end else if (pick < 23) begin
					sleep_converter($urandom_range(1, 5));
				end else begin
					random_read();
				end
			end
		end

		drain();
		$display("Sent %0d tick words in %0d reads with %0d register writes; %0d samples checked.",
			ticks_sent, reads_done, reg_writes, samples_seen);
		$display("Covered half periods 1 to 65535, reprogramming reads, bad requests and aborts.");
		if (mismatches == 0 && words_owed == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

FILE: filelist.f
design/lcasr_pkg.sv
design/lcasr_front.sv
design/lcasr_queue.sv
design/lcasr_back.sv
design/load_cell_adc_serial_reader_top.sv
dv/lcasr_checker.sv
dv/tb.sv
